// ===== src/bba_pkg.sv =====
// Shared types, constants and helpers for the bitmap block allocator.
// No dependencies; every other file in src imports this package.
package bba_pkg;

  localparam int BYTES_W = 13;   // request size field
  localparam int IDX_W   = 8;    // index fields on the channels
  localparam int CNT_W   = 9;    // blocks changed field
  localparam int NEED_W  = 14;   // rounded-up request size and its block count
  localparam int OP_W    = 5;

  localparam logic [7:0] RESERVED_ID  = 8'd5;
  localparam int         HINT_BACKOFF = 2;

  // datapath operations issued by the controller
  localparam logic [OP_W-1:0] OP_NOP          = 5'd0;
  localparam logic [OP_W-1:0] OP_CLR_STEP     = 5'd1;
  localparam logic [OP_W-1:0] OP_LATCH        = 5'd2;
  localparam logic [OP_W-1:0] OP_FREE_START   = 5'd3;
  localparam logic [OP_W-1:0] OP_FREE_ID      = 5'd4;
  localparam logic [OP_W-1:0] OP_FREE_CLR     = 5'd5;
  localparam logic [OP_W-1:0] OP_FREE_DONE    = 5'd6;
  localparam logic [OP_W-1:0] OP_FREE_REFUSE  = 5'd7;
  localparam logic [OP_W-1:0] OP_ALLOC_REFUSE = 5'd8;
  localparam logic [OP_W-1:0] OP_SIZE         = 5'd9;
  localparam logic [OP_W-1:0] OP_SCAN_INIT    = 5'd11;
  localparam logic [OP_W-1:0] OP_RUN_RD       = 5'd12;
  localparam logic [OP_W-1:0] OP_RUN_EXT      = 5'd13;
  localparam logic [OP_W-1:0] OP_RUN_FAIL     = 5'd14;
  localparam logic [OP_W-1:0] OP_FOUND        = 5'd15;
  localparam logic [OP_W-1:0] OP_GET_LEFT     = 5'd16;
  localparam logic [OP_W-1:0] OP_GET_RIGHT    = 5'd17;
  localparam logic [OP_W-1:0] OP_TAG          = 5'd18;
  localparam logic [OP_W-1:0] OP_ALLOC_DONE   = 5'd19;
  localparam logic [OP_W-1:0] OP_PUSH         = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;    // clearing sweep at last entry
    logic req_free;    // latched request is a free
    logic free_bad;    // free index out of range or reserved
    logic zero_bytes;  // allocate of zero bytes
    logic no_room;     // free blocks below blocks needed
    logic rd_zero;     // read entry is free
    logic run_full;    // this free entry completes the run
    logic run_edge;    // next probe would pass the map end
    logic scan_over;   // scan distance exhausted after this failure
    logic id_match;    // entry continues the run being freed
    logic tag_last;    // last entry of the run being tagged
    logic out_busy;    // result register still occupied
  } bba_status_t;

  // smallest ID above left (mod 256) that is neither 0 nor right
  function automatic logic [7:0] pick_id(input logic [7:0] left, input logic [7:0] right);
    logic [7:0] c;
    c = left + 8'd1;
    if (c == 8'd0) c = 8'd1;
    if (c == right) c = c + 8'd1;
    if (c == 8'd0) c = 8'd1;
    return c;
  endfunction

endpackage

// ===== src/bba_if.sv =====
// Request and response channel interfaces of the bitmap block allocator.
// Depends on bba_pkg for field widths.
interface bba_req_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [BYTES_W-1:0] alloc_bytes;
  logic [IDX_W-1:0]   free_index;

  modport source (output valid, action, alloc_bytes, free_index, input ready);
  modport sink   (input valid, action, alloc_bytes, free_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [IDX_W-1:0] start_index;
  logic [CNT_W-1:0] blocks_changed;

  modport source (output valid, ok, start_index, blocks_changed, input ready);
  modport sink   (input valid, ok, start_index, blocks_changed, output ready);
endinterface

// ===== src/bba_ctrl.sv =====
// Sequencing state machine of the bitmap block allocator.
// Depends on bba_pkg; drives the datapath through bba_cmd_t.
module bba_ctrl import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bba_status_t st,
  output bba_cmd_t    cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_FID    = 4'd3;
  localparam logic [3:0] S_FCHK   = 4'd4;
  localparam logic [3:0] S_ROOM   = 4'd6;
  localparam logic [3:0] S_SRD    = 4'd7;
  localparam logic [3:0] S_SCHK   = 4'd8;
  localparam logic [3:0] S_LEFT   = 4'd9;
  localparam logic [3:0] S_RIGHT  = 4'd10;
  localparam logic [3:0] S_TAG    = 4'd11;
  localparam logic [3:0] S_ADONE  = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.req_free) begin
          if (st.free_bad) begin
            cmd.op    = OP_FREE_REFUSE;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = OP_FREE_START;
            state_nxt = S_FID;
          end
        end else if (st.zero_bytes) begin
          cmd.op    = OP_ALLOC_REFUSE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_SIZE;
          state_nxt = S_ROOM;
        end
      end
      S_FID: begin
        if (st.rd_zero) begin
          cmd.op    = OP_FREE_REFUSE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_FREE_ID;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (st.id_match) begin
          cmd.op = OP_FREE_CLR;
        end else begin
          cmd.op    = OP_FREE_DONE;
          state_nxt = S_FIN;
        end
      end
      S_ROOM: begin
        if (st.no_room) begin
          cmd.op    = OP_ALLOC_REFUSE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.op    = OP_RUN_RD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (st.rd_zero && st.run_full) begin
          cmd.op    = OP_FOUND;
          state_nxt = S_LEFT;
        end else if (st.rd_zero && !st.run_edge) begin
          cmd.op = OP_RUN_EXT;
        end else if (st.scan_over) begin
          cmd.op    = OP_ALLOC_REFUSE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_RUN_FAIL;
          state_nxt = S_SRD;
        end
      end
      S_LEFT: begin
        cmd.op    = OP_GET_LEFT;
        state_nxt = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.op    = OP_GET_RIGHT;
        state_nxt = S_TAG;
      end
      S_TAG: begin
        cmd.op = OP_TAG;
        if (st.tag_last) state_nxt = S_ADONE;
      end
      S_ADONE: begin
        cmd.op    = OP_ALLOC_DONE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/bba_dpath.sv =====
// Datapath of the bitmap block allocator: run ID map memory, scan and run
// registers, size scaler and result registers. Depends on bba_pkg, bba_if.
module bba_dpath import bba_pkg::*; #(
  parameter int ENTRIES     = 256,
  parameter int BLOCK_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bba_cmd_t           cmd,
  output bba_status_t        st,
  input  logic               in_action,
  input  logic [BYTES_W-1:0] in_alloc_bytes,
  input  logic [IDX_W-1:0]   in_free_index,
  bba_rsp_if.source          out_rsp
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int DW   = CW + 1;
  localparam int MW   = (CW > NEED_W) ? CW : NEED_W;
  localparam int XW   = (CW > IDX_W) ? CW + 1 : IDX_W + 1;
  localparam int RSV  = (ENTRIES + BLOCK_BYTES - 1) / BLOCK_BYTES;
  // reciprocal of the block size, exact for any NEED_W-bit numerator
  localparam int SH_W = NEED_W + $clog2(BLOCK_BYTES);
  localparam int PW   = 2 * NEED_W + 2;

  localparam logic [CW-1:0]     E_C    = CW'(ENTRIES);
  localparam logic [DW-1:0]     E_D    = DW'(ENTRIES);
  localparam logic [CW-1:0]     RSV_C  = CW'(RSV);
  localparam logic [NEED_W-1:0] BB_C   = NEED_W'(BLOCK_BYTES);
  localparam logic [IW-1:0]     LAST_I = IW'(ENTRIES - 1);
  localparam logic [PW-1:0]     RCP_C  =
    PW'(((1 << SH_W) + BLOCK_BYTES - 1) / BLOCK_BYTES);

  // run ID map
  logic [7:0]    run_map_r [ENTRIES];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  // request and control state
  logic               action_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [IW-1:0]      clr_r;
  logic [IW-1:0]      hint_r;
  logic [CW-1:0]      used_r;
  logic [IW-1:0]      x_r;
  logic [CW-1:0]      y_r;
  logic [DW-1:0]      d_r;
  logic [CW-1:0]      pos_r;
  logic [7:0]         id_r, left_r;
  logic [NEED_W-1:0]  need_r;

  logic               res_ok_r;
  logic [IDX_W-1:0]   res_start_r;
  logic [CNT_W-1:0]   res_cnt_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [IDX_W-1:0]   out_start_r;
  logic [CNT_W-1:0]   out_cnt_r;

  // derived values
  logic [NEED_W-1:0] num_w, need_calc;
  logic [PW-1:0]     prod_w;
  logic [CW-1:0]     sum_xy, sum_xy1, y_inc, free_cnt, free_blk;
  logic [DW-1:0]     d_inc, d_nxt, hint_sum, hint_wrap;
  logic [XW-1:0]     idx_x;
  logic [7:0]        right_w;

  // blocks needed = ceil(bytes / BLOCK_BYTES) by reciprocal multiply
  assign num_w     = NEED_W'(bytes_r) + (BB_C - NEED_W'(1));
  assign prod_w    = PW'(num_w) * RCP_C;
  assign need_calc = NEED_W'(prod_w >> SH_W);

  assign sum_xy   = CW'(x_r) + y_r;
  assign sum_xy1  = sum_xy + CW'(1);
  assign y_inc    = y_r + CW'(1);
  assign free_cnt = pos_r - CW'(free_idx_r);
  assign free_blk = E_C - used_r;
  assign idx_x    = XW'(free_idx_r);
  assign right_w  = (sum_xy != E_C) ? rd_data_r : 8'd0;

  // distance advance after a failed run
  always_comb begin
    if (rd_data_r == 8'd0)  d_inc = DW'(y_inc);
    else if (y_r == '0)     d_inc = DW'(1);
    else                    d_inc = DW'(y_r);
    d_nxt    = d_r + d_inc;
    hint_sum = DW'(hint_r) + d_nxt;
    if (hint_sum >= E_D) hint_sum = hint_sum - E_D;
    hint_wrap = DW'(sum_xy) + DW'(ENTRIES - HINT_BACKOFF);
    if (hint_wrap >= E_D) hint_wrap = hint_wrap - E_D;
  end

  always_comb begin
    st.clr_last   = (clr_r == LAST_I);
    st.req_free   = action_r;
    st.free_bad   = (idx_x >= XW'(ENTRIES)) || (idx_x < XW'(RSV));
    st.zero_bytes = (bytes_r == '0);
    st.no_room    = (MW'(free_blk) < MW'(need_r));
    st.rd_zero    = (rd_data_r == 8'd0);
    st.run_full   = (MW'(y_inc) == MW'(need_r));
    st.run_edge   = (sum_xy1 == E_C);
    st.scan_over  = (d_nxt >= E_D);
    st.id_match   = (pos_r != E_C) && (rd_data_r == id_r);
    st.tag_last   = ((pos_r + CW'(1)) == sum_xy);
    st.out_busy   = out_valid_r && !out_rsp.ready;
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_r[IW-1:0];
    mem_wd = 8'd0;
    mem_ra = '0;
    case (cmd.op)
      OP_CLR_STEP: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = (CW'(clr_r) < RSV_C) ? RESERVED_ID : 8'd0;
      end
      OP_FREE_START: mem_ra = IW'(free_idx_r);
      OP_FREE_ID:    mem_ra = pos_r[IW-1:0];
      OP_FREE_CLR: begin
        mem_we = 1'b1;
        mem_ra = IW'(pos_r + CW'(1));
      end
      OP_RUN_RD:   mem_ra = sum_xy[IW-1:0];
      OP_RUN_EXT:  mem_ra = sum_xy1[IW-1:0];
      OP_FOUND:    mem_ra = x_r - IW'(1);
      OP_GET_LEFT: mem_ra = sum_xy[IW-1:0];
      OP_TAG: begin
        mem_we = 1'b1;
        mem_wd = id_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) run_map_r[mem_wa] <= mem_wd;
    rd_data_r <= run_map_r[mem_ra];
  end

  // control state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      hint_r      <= IW'(RSV - 1);
      used_r      <= RSV_C;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_PUSH) out_valid_r <= 1'b1;
      else if (out_valid_r && out_rsp.ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CLR_STEP:   clr_r <= clr_r + IW'(1);
        OP_FREE_DONE:  used_r <= (used_r >= free_cnt) ? used_r - free_cnt : '0;
        OP_ALLOC_DONE: begin
          used_r <= used_r + y_r;
          hint_r <= IW'(hint_wrap);
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        action_r   <= in_action;
        bytes_r    <= in_alloc_bytes;
        free_idx_r <= in_free_index;
      end
      OP_FREE_START: pos_r <= CW'(free_idx_r);
      OP_FREE_ID:    id_r <= rd_data_r;
      OP_FREE_CLR:   pos_r <= pos_r + CW'(1);
      OP_FREE_DONE: begin
        res_ok_r    <= 1'b1;
        res_start_r <= free_idx_r;
        res_cnt_r   <= CNT_W'(free_cnt);
      end
      OP_FREE_REFUSE: begin
        res_ok_r    <= 1'b0;
        res_start_r <= free_idx_r;
        res_cnt_r   <= '0;
      end
      OP_ALLOC_REFUSE: begin
        res_ok_r    <= 1'b0;
        res_start_r <= '0;
        res_cnt_r   <= '0;
      end
      OP_SIZE:       need_r <= need_calc;
      OP_SCAN_INIT: begin
        d_r <= DW'(1);
        x_r <= (hint_r == LAST_I) ? '0 : hint_r + IW'(1);
        y_r <= '0;
      end
      OP_RUN_EXT, OP_FOUND: y_r <= y_inc;
      OP_RUN_FAIL: begin
        d_r <= d_nxt;
        x_r <= IW'(hint_sum);
        y_r <= '0;
      end
      OP_GET_LEFT:  left_r <= (x_r == '0) ? 8'd0 : rd_data_r;
      OP_GET_RIGHT: begin
        id_r  <= pick_id(left_r, right_w);
        pos_r <= CW'(x_r);
      end
      OP_TAG:       pos_r <= pos_r + CW'(1);
      OP_ALLOC_DONE: begin
        res_ok_r    <= 1'b1;
        res_start_r <= IDX_W'(x_r);
        res_cnt_r   <= CNT_W'(y_r);
      end
      OP_PUSH: begin
        out_ok_r    <= res_ok_r;
        out_start_r <= res_start_r;
        out_cnt_r   <= res_cnt_r;
      end
      default: ;
    endcase
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.ok             = out_ok_r;
  assign out_rsp.start_index    = out_start_r;
  assign out_rsp.blocks_changed = out_cnt_r;

endmodule

// ===== src/bitmap_block_allocator_unit.sv =====
// Bitmap block allocator: a pool map of per-block run IDs (0 = free) with
// allocate and free requests. Depends on bba_pkg, bba_if, bba_ctrl, bba_dpath.
//
// Usage notes
//   in_req  : request channel. action 0 allocates alloc_bytes bytes, action 1
//             frees the run that starts at free_index. A request is taken when
//             valid and ready are both high; ready is high only while the unit
//             has no request in progress.
//   out_rsp : one response per request: ok, start_index, blocks_changed.
//   Reset   : synchronous, active low. After reset a clearing sweep writes the
//             map, one entry per cycle, through every entry (reserved head
//             entries get ID 5); no request is taken during the sweep.
//   Steps   : free = check, read the start entry's ID, then clear each entry of
//             the run. Allocate = size, room check, then probe run starts and
//             further entries inside a run, read both neighbours and tag each
//             entry; the block count is a reciprocal multiply. The single map
//             read port, one entry per cycle, paces the scan.
//   Stall   : the response sits in an output register; the next request is
//             accepted and worked on while it waits, and that request's result
//             holds until the register drains.
module bitmap_block_allocator_unit import bba_pkg::*; #(
  parameter int ENTRIES     = 256,
  parameter int BLOCK_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bba_req_if.sink   in_req,
  bba_rsp_if.source out_rsp
);

  bba_cmd_t    cmd;     // operation for this cycle
  bba_status_t st;      // datapath flags back to the sequencer
  logic        ready;

  assign in_req.ready = ready;

  // sequencer: owns the request handshake and steps the datapath
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ready),
    .st       (st),
    .cmd      (cmd)
  );

  // map memory, scan registers, size scaler and response register
  bba_dpath #(
    .ENTRIES     (ENTRIES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_action      (in_req.action),
    .in_alloc_bytes (in_req.alloc_bytes),
    .in_free_index  (in_req.free_index),
    .out_rsp        (out_rsp)
  );

endmodule
